// File: hdl/cfgrec_pkg.sv
// Shared types, constants and helper functions for the config record checker.
// No dependencies; used by the channel interfaces and the checker core.
package cfgrec_pkg;

   localparam int unsigned RECORD_BYTES  = 64;
   localparam int unsigned POS_W         = $clog2(RECORD_BYTES);
   localparam int unsigned PAYLOAD_LEN   = 30;
   localparam int unsigned PAYLOAD_FIRST = 8;
   localparam int unsigned PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);
   localparam int unsigned RESERVED_TAIL = 38;
   localparam int unsigned CRC_AT        = 60;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   // 'J','S','C','3', byte 0 in the low slot
   localparam logic [3:0][7:0] MAGIC = {8'h33, 8'h43, 8'h53, 8'h4A};

   localparam logic [7:0]  VERSION_RESET  = 8'd1;
   localparam logic [15:0] ADC_MAX_RESET  = 16'd4095;
   localparam logic [15:0] MIN_SPAN_RESET = 16'd256;
   localparam logic [15:0] Q15_RESET      = 16'd32767;

   typedef logic [PAYLOAD_LEN-1:0][7:0] payload_type;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_MAGIC      = 4'd1,
      ST_VERSION    = 4'd2,
      ST_LENGTH     = 4'd3,
      ST_RESERVED   = 4'd4,
      ST_CRC        = 4'd5,
      ST_GENERATION = 4'd6,
      ST_AXIS       = 4'd7,
      ST_SHAPING    = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      CSR_VERSION  = 2'd0,
      CSR_ADC_MAX  = 2'd1,
      CSR_MIN_SPAN = 2'd2,
      CSR_Q15      = 2'd3
   } csr_index_type;

   localparam logic [3:0] FID_GENERATION = 4'd0;
   localparam logic [3:0] FID_X_INVERT   = 4'd5;
   localparam logic [3:0] FID_Y_INVERT   = 4'd10;
   localparam logic [3:0] FID_PROFILE    = 4'd13;

   // header error flag bits
   localparam int unsigned HF_MAGIC    = 0;
   localparam int unsigned HF_VERSION  = 1;
   localparam int unsigned HF_LENGTH   = 2;
   localparam int unsigned HF_RESERVED = 3;

   // one byte of reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic axis_bad(input logic [15:0] mn, input logic [15:0] ct,
                                     input logic [15:0] mx, input logic [15:0] db,
                                     input logic [15:0] adc_max,
                                     input logic [15:0] min_span);
      logic [15:0] neg;
      logic [15:0] pos;
      neg = ct - mn;
      pos = mx - ct;
      if (mx > adc_max || mn >= ct || ct >= mx) begin
         return 1'b1;
      end
      return (neg < min_span) || (pos < min_span) || (db == 16'd0) ||
             (db >= neg) || (db >= pos);
   endfunction

endpackage

// File: hdl/cfgrec_if.sv
// Valid/ready channel interfaces: record byte requests, decoded results, CSR writes.
// Depends on cfgrec_pkg.
interface cfgrec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface cfgrec_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [3:0]  field_id;
   logic [31:0] field_value;
   logic        last_item;
   modport source (output valid, output status, output field_id, output field_value,
                   output last_item, input ready);
   modport sink   (input valid, input status, input field_id, input field_value,
                   input last_item, output ready);
endinterface

interface cfgrec_csr_if;
   logic                         valid;
   logic                         ready;
   cfgrec_pkg::csr_index_type    index;
   logic [15:0]                  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/config_record_checker_core.sv
// Config record checker: header/reserved checks, CRC-32, field validation and decode.
// Depends on cfgrec_pkg and the channel interfaces in cfgrec_if.sv.
// Throughput: one record byte per cycle. Results: the first is valid the cycle after the last
// record byte (byte 63) is accepted; the run is 14 items, or one error item, at one item per
// cycle while ready is high. A request at record position 63 stalls only while a run drains.
// Reset (synchronous): position 0, CRC all ones, flags cleared, registers to defaults.
module config_record_checker_core (
   input  logic         clock,
   input  logic         reset,
   cfgrec_req_if.sink   req_bus,
   cfgrec_rsp_if.source rsp_bus,
   cfgrec_csr_if.sink   csr_bus
);

   localparam int unsigned POS_W = cfgrec_pkg::POS_W;

   // configuration
   logic [7:0]  version_ff;
   logic [15:0] adc_max_ff;
   logic [15:0] min_span_ff;
   logic [15:0] q15_ff;

   // record state
   logic [POS_W-1:0]        pos_ff,  pos_in;
   logic [31:0]             crc_ff,  crc_in;
   logic [3:0]              hdr_ff,  hdr_in;
   logic [31:0]             rcv_ff,  rcv_in;
   cfgrec_pkg::payload_type store_ff;

   // result run
   logic                    busy_ff, busy_in;
   logic [3:0]              fid_ff,  fid_in;
   cfgrec_pkg::status_type  status_ff, status_in;
   cfgrec_pkg::payload_type snap_ff, snap_in;

   logic             req_acc;
   logic             rsp_acc;
   logic [POS_W-1:0] p;
   logic             last_pos;
   logic [7:0]       b;
   logic             store_we;
   logic [POS_W-1:0] store_off;
   logic [31:0]      rcv_full;
   logic             run_done;
   cfgrec_pkg::status_type chk_status;

   assign req_acc = req_bus.valid && req_bus.ready;
   assign rsp_acc = rsp_bus.valid && rsp_bus.ready;
   assign b       = req_bus.data_byte;
   assign p       = req_bus.first_byte ? '0 : pos_ff;
   assign last_pos = (p == POS_W'(cfgrec_pkg::RECORD_BYTES - 1));

   // a record's last byte waits until the previous run has drained
   assign req_bus.ready = !(busy_ff && pos_ff == POS_W'(cfgrec_pkg::RECORD_BYTES - 1));
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff  <= cfgrec_pkg::VERSION_RESET;
         adc_max_ff  <= cfgrec_pkg::ADC_MAX_RESET;
         min_span_ff <= cfgrec_pkg::MIN_SPAN_RESET;
         q15_ff      <= cfgrec_pkg::Q15_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            cfgrec_pkg::CSR_VERSION:  version_ff  <= csr_bus.data[7:0];
            cfgrec_pkg::CSR_ADC_MAX:  adc_max_ff  <= csr_bus.data;
            cfgrec_pkg::CSR_MIN_SPAN: min_span_ff <= csr_bus.data;
            cfgrec_pkg::CSR_Q15:      q15_ff      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // per-byte header checks, CRC and trailer capture
   always_comb begin
      hdr_in = (p == '0) ? 4'd0 : hdr_ff;
      if (p < POS_W'(4)) begin
         if (b != cfgrec_pkg::MAGIC[p[1:0]]) hdr_in[cfgrec_pkg::HF_MAGIC] = 1'b1;
      end else if (p == POS_W'(4)) begin
         if (b != version_ff) hdr_in[cfgrec_pkg::HF_VERSION] = 1'b1;
      end else if (p == POS_W'(5)) begin
         if (b != 8'(cfgrec_pkg::PAYLOAD_LEN)) hdr_in[cfgrec_pkg::HF_LENGTH] = 1'b1;
      end else if (p == POS_W'(6) || p == POS_W'(7) || p == POS_W'(21) ||
                   p == POS_W'(31) ||
                   (p >= POS_W'(cfgrec_pkg::RESERVED_TAIL) &&
                    p <  POS_W'(cfgrec_pkg::CRC_AT))) begin
         if (b != 8'd0) hdr_in[cfgrec_pkg::HF_RESERVED] = 1'b1;
      end else if (p == POS_W'(20) || p == POS_W'(30)) begin
         if (b > 8'd1) hdr_in[cfgrec_pkg::HF_RESERVED] = 1'b1;
      end

      crc_in = crc_ff;
      rcv_in = (p == '0) ? 32'd0 : rcv_ff;
      if (p < POS_W'(cfgrec_pkg::CRC_AT)) begin
         crc_in = cfgrec_pkg::crc_byte((p == '0) ? cfgrec_pkg::CRC_ONES : crc_ff, b);
      end else begin
         // trailer starts at a multiple of four, so the low bits give the byte lane
         rcv_in[8*p[1:0] +: 8] = b;
      end
      pos_in = p + POS_W'(1);
   end

   assign store_off = p - POS_W'(cfgrec_pkg::PAYLOAD_FIRST);
   assign store_we  = req_acc && p >= POS_W'(cfgrec_pkg::PAYLOAD_FIRST) &&
                      p < POS_W'(cfgrec_pkg::PAYLOAD_FIRST + cfgrec_pkg::PAYLOAD_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= cfgrec_pkg::CRC_ONES;
         hdr_ff <= '0;
         rcv_ff <= '0;
      end else if (req_acc) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         hdr_ff <= hdr_in;
         rcv_ff <= rcv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_off[cfgrec_pkg::PAYLOAD_IDX_W-1:0]] <= b;
      end
   end

   // final verdict, evaluated while the last byte is presented
   assign rcv_full = {b, rcv_ff[23:0]};

   always_comb begin
      if (hdr_ff[cfgrec_pkg::HF_MAGIC]) begin
         chk_status = cfgrec_pkg::ST_MAGIC;
      end else if (hdr_ff[cfgrec_pkg::HF_VERSION]) begin
         chk_status = cfgrec_pkg::ST_VERSION;
      end else if (hdr_ff[cfgrec_pkg::HF_LENGTH]) begin
         chk_status = cfgrec_pkg::ST_LENGTH;
      end else if (hdr_ff[cfgrec_pkg::HF_RESERVED]) begin
         chk_status = cfgrec_pkg::ST_RESERVED;
      end else if (~crc_ff != rcv_full) begin
         chk_status = cfgrec_pkg::ST_CRC;
      end else if ({store_ff[3], store_ff[2], store_ff[1], store_ff[0]} == 32'd0) begin
         chk_status = cfgrec_pkg::ST_GENERATION;
      end else if (cfgrec_pkg::axis_bad({store_ff[5], store_ff[4]}, {store_ff[7], store_ff[6]},
                                        {store_ff[9], store_ff[8]},
                                        {store_ff[11], store_ff[10]},
                                        adc_max_ff, min_span_ff) ||
                   cfgrec_pkg::axis_bad({store_ff[15], store_ff[14]},
                                        {store_ff[17], store_ff[16]},
                                        {store_ff[19], store_ff[18]},
                                        {store_ff[21], store_ff[20]},
                                        adc_max_ff, min_span_ff)) begin
         chk_status = cfgrec_pkg::ST_AXIS;
      end else if ({store_ff[25], store_ff[24]} == 16'd0 ||
                   {store_ff[25], store_ff[24]} > q15_ff ||
                   {store_ff[27], store_ff[26]} > q15_ff) begin
         chk_status = cfgrec_pkg::ST_SHAPING;
      end else begin
         chk_status = cfgrec_pkg::ST_OK;
      end
   end

   // result run: snapshot shifts down by one field per delivered item
   assign run_done = (status_ff != cfgrec_pkg::ST_OK) || (fid_ff == cfgrec_pkg::FID_PROFILE);

   always_comb begin
      busy_in   = busy_ff;
      fid_in    = fid_ff;
      status_in = status_ff;
      snap_in   = snap_ff;
      if (req_acc && last_pos) begin
         busy_in   = 1'b1;
         fid_in    = cfgrec_pkg::FID_GENERATION;
         status_in = chk_status;
         snap_in   = store_ff;
      end else if (rsp_acc) begin
         if (run_done) begin
            busy_in = 1'b0;
         end else begin
            fid_in  = fid_ff + 4'd1;
            snap_in = (fid_ff == cfgrec_pkg::FID_GENERATION) ? (snap_ff >> 32)
                                                              : (snap_ff >> 16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         fid_ff    <= cfgrec_pkg::FID_GENERATION;
         status_ff <= cfgrec_pkg::ST_OK;
      end else begin
         busy_ff   <= busy_in;
         fid_ff    <= fid_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign rsp_bus.valid     = busy_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.field_id  = fid_ff;
   assign rsp_bus.last_item = run_done;

   always_comb begin
      if (status_ff != cfgrec_pkg::ST_OK) begin
         rsp_bus.field_value = 32'd0;
      end else if (fid_ff == cfgrec_pkg::FID_GENERATION) begin
         rsp_bus.field_value = {snap_ff[3], snap_ff[2], snap_ff[1], snap_ff[0]};
      end else if (fid_ff == cfgrec_pkg::FID_X_INVERT ||
                   fid_ff == cfgrec_pkg::FID_Y_INVERT) begin
         rsp_bus.field_value = {24'd0, snap_ff[0]};
      end else begin
         rsp_bus.field_value = {16'd0, snap_ff[1], snap_ff[0]};
      end
   end

   // checks
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_pos) |=> (busy_ff && fid_ff == cfgrec_pkg::FID_GENERATION))
      else $error("result run did not start after last record byte");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_bus.last_item) |=> !busy_ff)
      else $error("result run continued past its last item");

   a_fid_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> fid_ff <= cfgrec_pkg::FID_PROFILE)
      else $error("field id out of range");

   a_error_item: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && status_ff != cfgrec_pkg::ST_OK) |->
         (fid_ff == cfgrec_pkg::FID_GENERATION && rsp_bus.field_value == 32'd0))
      else $error("error item carries a field");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_bus.first_byte) |=> pos_ff == POS_W'(1))
      else $error("start mark did not restart the record");

endmodule
